// ----- rtl/gibim_pkg.sv -----
// Shared types and constants of the base (i-1) converter.
package gibim_pkg;

   localparam int FIELD_BITS = 16;                // width of each input part
   localparam int WORK_BITS  = FIELD_BITS + 2;    // working width of the x/y registers
   localparam int DIGIT_BITS = 64;                // packed digit word
   localparam int COUNT_BITS = 7;                 // digit count field

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } state_type;

   // Control broadcast to every digit cell.
   typedef struct packed {
      logic clr;     // start of a new conversion
      logic step;    // one digit produced this cycle
      logic digit;   // value of that digit
   } cell_ctrl_type;

endpackage

// ----- rtl/gibim_if.sv -----
// Valid/ready channels of the base (i-1) converter.
interface gibim_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [gibim_pkg::FIELD_BITS-1:0] real_part;
   logic signed [gibim_pkg::FIELD_BITS-1:0] imag_part;

   modport source (output valid, output real_part, output imag_part, input ready);
   modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

interface gibim_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [gibim_pkg::DIGIT_BITS-1:0] digit_bits;
   logic [gibim_pkg::COUNT_BITS-1:0] digit_count;

   modport source (output valid, output digit_bits, output digit_count, input ready);
   modport sink   (input valid, input digit_bits, input digit_count, output ready);
endinterface

// ----- rtl/gibim_cell.sv -----
// One digit cell: holds a digit and the write token, passes the token right.
module gibim_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  gibim_pkg::cell_ctrl_type ctrl,
   input  logic                     is_head,
   input  logic                     tok_left,
   output logic                     tok_out,
   output logic                     digit_out
);

   logic token_ff, token_in;
   logic digit_ff, digit_in;

   always_comb begin
      token_in = token_ff;
      digit_in = digit_ff;
      if (ctrl.clr) begin
         token_in = is_head;
         digit_in = 1'b0;
      end else if (ctrl.step) begin
         if (token_ff) begin
            digit_in = ctrl.digit;
         end
         token_in = tok_left;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= 1'b0;
      end else begin
         token_ff <= token_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign tok_out   = token_ff;
   assign digit_out = digit_ff;

endmodule

// ----- rtl/gaussian_int_to_base_i_minus_one.sv -----
// Top level: Gaussian integer to complex base (i-1) digit string converter.
//
//   channel   dir   word                          handshake
//   req_ch    in    real_part, imag_part          valid/ready
//   rsp_ch    out   digit_bits, digit_count       valid/ready
//
// An item with n digits (n <= MAX_DIGITS) is loaded, runs one x/y update step
// per digit, and is then handed to the output register.
// Digits are written by a token that walks the row of digit cells.
// A new word is taken while a finished one waits in the output register; the
// next finish then holds in RUN until that register drains.
// Synchronous active-high reset clears the control state and the output valid.
module gaussian_int_to_base_i_minus_one #(
   parameter int VALUE_BITS = 16,
   parameter int MAX_DIGITS = 64
) (
   input logic         clock,
   input logic         reset,
   gibim_req_if.sink   req_ch,
   gibim_rsp_if.source rsp_ch
);

   localparam int WB    = gibim_pkg::WORK_BITS;
   localparam int EXT_W = (VALUE_BITS < gibim_pkg::FIELD_BITS) ? VALUE_BITS
                                                               : gibim_pkg::FIELD_BITS;
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);

   gibim_pkg::state_type state_ff, state_in;

   logic signed [WB-1:0] x_ff, x_in, y_ff, y_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [gibim_pkg::DIGIT_BITS-1:0]     rsp_bits_ff, rsp_bits_in;
   logic [gibim_pkg::COUNT_BITS-1:0]     rsp_count_ff, rsp_count_in;

   logic accept_w, running_w, finish_w, out_free_w;
   logic digit_w;
   logic signed [WB-1:0] xa_w, nx_w, ny_w, x_load_w, y_load_w;
   logic signed [WB:0]   dif_w, sum_w, neg_w;

   gibim_pkg::cell_ctrl_type ctrl_w;
   logic [MAX_DIGITS-1:0]    tok_w;
   logic [MAX_DIGITS-1:0]    digits_w;

   // Sign extension from the effective value width.
   assign x_load_w = {{(WB-EXT_W){req_ch.real_part[EXT_W-1]}}, req_ch.real_part[EXT_W-1:0]};
   assign y_load_w = {{(WB-EXT_W){req_ch.imag_part[EXT_W-1]}}, req_ch.imag_part[EXT_W-1:0]};

   // One division by (i-1): after removing the digit, x+y is even so the halvings are exact.
   assign digit_w = x_ff[0] ^ y_ff[0];
   assign xa_w    = x_ff - WB'(digit_w);
   assign dif_w   = {y_ff[WB-1], y_ff} - {xa_w[WB-1], xa_w};
   assign sum_w   = {xa_w[WB-1], xa_w} + {y_ff[WB-1], y_ff};
   assign neg_w   = -sum_w;
   assign nx_w    = dif_w[WB:1];
   assign ny_w    = neg_w[WB:1];

   assign running_w  = ((x_ff != '0) || (y_ff != '0)) && (count_ff < CNT_W'(MAX_DIGITS));
   assign out_free_w = !rsp_valid_ff || rsp_ch.ready;
   assign accept_w   = req_ch.valid && req_ch.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gibim_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = gibim_pkg::ST_RUN;
            end
         end
         gibim_pkg::ST_RUN: begin
            if (!running_w && out_free_w) begin
               state_in = gibim_pkg::ST_IDLE;
            end
         end
         default: state_in = gibim_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_ch.ready = 1'b0;
      finish_w     = 1'b0;
      ctrl_w       = '0;
      unique case (state_ff)
         gibim_pkg::ST_IDLE: begin
            // no word is taken while reset is held
            req_ch.ready = !reset;
            ctrl_w.clr   = req_ch.valid;
         end
         gibim_pkg::ST_RUN: begin
            ctrl_w.step  = running_w;
            ctrl_w.digit = digit_w;
            finish_w     = !running_w && out_free_w;
         end
         default: ;
      endcase
   end

   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      count_in = count_ff;
      if (accept_w) begin
         x_in     = x_load_w;
         y_in     = y_load_w;
         count_in = '0;
      end else if (ctrl_w.step) begin
         x_in     = nx_w;
         y_in     = ny_w;
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_bits_in  = rsp_bits_ff;
      rsp_count_in = rsp_count_ff;
      if (finish_w) begin
         rsp_valid_in = 1'b1;
         rsp_bits_in  = gibim_pkg::DIGIT_BITS'(digits_w);
         // zero input still reports one digit
         rsp_count_in = (count_ff == '0) ? gibim_pkg::COUNT_BITS'(1)
                                         : gibim_pkg::COUNT_BITS'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gibim_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      count_ff     <= count_in;
      rsp_bits_ff  <= rsp_bits_in;
      rsp_count_ff <= rsp_count_in;
   end

   for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
      gibim_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl_w),
         .is_head   ((k == 0) ? 1'b1 : 1'b0),
         .tok_left  ((k == 0) ? 1'b0 : tok_w[(k == 0) ? 0 : k-1]),
         .tok_out   (tok_w[k]),
         .digit_out (digits_w[k])
      );
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.digit_bits  = rsp_bits_ff;
   assign rsp_ch.digit_count = rsp_count_ff;

endmodule

// ----- rtl/gibim_checker.sv -----
// Port-level checks of the base (i-1) converter, bound to the top level.
module gibim_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [gibim_pkg::DIGIT_BITS-1:0] digit_bits,
   input logic [gibim_pkg::COUNT_BITS-1:0] digit_count
);

   // A held result word does not change while stalled.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && !reset |=> rsp_valid && $stable(digit_bits)
                                            && $stable(digit_count))
      else $error("result word changed while stalled");

   // Count is always within one to the full word.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (digit_count != '0) && (digit_count <= gibim_pkg::COUNT_BITS'(64)))
      else $error("digit count out of range");

   // Digits past the count are zero.
   a_upper_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((digit_bits >> digit_count) == '0))
      else $error("digit set above digit count");

   // The converter is busy right after it takes a word.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !reset |=> !req_ready)
      else $error("new word taken during conversion");

endmodule

bind gaussian_int_to_base_i_minus_one gibim_checker u_gibim_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .digit_bits  (rsp_ch.digit_bits),
   .digit_count (rsp_ch.digit_count)
);
